>>> hdl/ctsc_pkg.sv
// Package for the comfort turn signal controller.
// Holds the mode codes, the sample bit layout, hold masks and register indexes.
// No dependencies; every other file of the block uses it.
package ctsc_pkg;

  // Operating mode, also shown on the result as mode_code
  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_TURN_L = 3'd1,
    MODE_TURN_R = 3'd2,
    MODE_THANKS = 3'd3,
    MODE_AWAIT  = 3'd4
  } mode_t;

  // Sample layout: bit 0 right lever idle, bit 1 left lever idle, bit 2 relay on
  localparam int unsigned SAMPLE_W  = 3;
  localparam int unsigned BIT_RIGHT = 0;
  localparam int unsigned BIT_LEFT  = 1;
  localparam int unsigned BIT_RELAY = 2;
  typedef logic [SAMPLE_W-1:0] sample_t;

  // Sample patterns that the idle judgment and release check look for
  localparam sample_t SMP_BOTH_ACTIVE_OFF = 3'b000;
  localparam sample_t SMP_RELEASED_OFF    = 3'b011;
  localparam sample_t SMP_LEFT_TAP_ON     = 3'b101;
  localparam sample_t SMP_RIGHT_TAP_ON    = 3'b110;
  localparam sample_t SMP_HAZARD_ON       = 3'b111;

  // Hold drive masks: bit 0 left, bit 1 right
  typedef logic [1:0] hold_t;
  localparam hold_t HOLD_NONE = 2'b00;
  localparam hold_t HOLD_L    = 2'b01;
  localparam hold_t HOLD_R    = 2'b10;

  // Counters are 8 bits
  localparam int unsigned CNT_W = 8;
  typedef logic [CNT_W-1:0] cnt_t;

  // Configuration register file
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;
  typedef enum logic [1:0] {
    REG_TURN_BLINKS   = 2'd0,
    REG_THANKS_BLINKS = 2'd1,
    REG_HOLDOFF       = 2'd2
  } reg_idx_t;

  localparam cnt_t TURN_BLINKS_RST   = 8'd4;
  localparam cnt_t THANKS_BLINKS_RST = 8'd0;
  localparam cnt_t HOLDOFF_RST       = 8'd4;

endpackage

>>> hdl/ctsc_if.sv
// Valid/ready channel interfaces for the comfort turn signal controller.
// Depends on ctsc_pkg for the mode type.
interface ctsc_in_if;
  logic valid;
  logic ready;
  logic right_lever_idle;
  logic left_lever_idle;
  logic relay_on;

  modport source (output valid, right_lever_idle, left_lever_idle, relay_on, input ready);
  modport sink   (input valid, right_lever_idle, left_lever_idle, relay_on, output ready);
endinterface

interface ctsc_out_if;
  logic            valid;
  logic            ready;
  logic            hold_left;
  logic            hold_right;
  ctsc_pkg::mode_t mode_code;
  logic            sample_taken;

  modport source (output valid, hold_left, hold_right, mode_code, sample_taken, input ready);
  modport sink   (input valid, hold_left, hold_right, mode_code, sample_taken, output ready);
endinterface

>>> hdl/comfort_turn_signal_controller.sv
// Comfort turn signal controller, top level.
// Depends on ctsc_pkg and the channel interfaces in ctsc_if.sv.
//
// Takes one sample of the levers and flasher relay per transfer and returns
// one result per sample; a sample may be offered every clock cycle. The
// whole state update is one pass of logic between the accepted sample and
// the result register, so the throughput is one sample per cycle and each
// result appears in the cycle after its sample is accepted. A new sample
// is taken while the result register is empty or being drained in the same
// cycle. Configuration goes through the APB port (byte addresses 0, 4, 8)
// and is meant to be written while no sample is in flight.
module comfort_turn_signal_controller (
  input  logic                         clk,
  input  logic                         rst,
  ctsc_in_if.sink                      in_ch,
  ctsc_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ctsc_pkg::APB_AW-1:0]  paddr,
  input  logic [ctsc_pkg::APB_DW-1:0]  pwdata,
  output logic [ctsc_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import ctsc_pkg::*;

  // Configuration registers
  cnt_t     turn_blinks;
  cnt_t     thanks_blinks;
  cnt_t     holdoff_samples;
  reg_idx_t reg_sel;
  logic     cfg_wr;

  // Controller state
  mode_t   mode, mode_next;
  cnt_t    blinks_done, blinks_done_next;
  sample_t last_sample;
  logic    awaiting_relay_on, awaiting_relay_on_next;
  cnt_t    holdoff_left, holdoff_left_next;
  hold_t   hold_outputs, hold_outputs_next;
  logic    taken;

  // Handshake
  logic    in_fire;
  sample_t smp;
  logic    cancel;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[APB_AW-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      turn_blinks     <= TURN_BLINKS_RST;
      thanks_blinks   <= THANKS_BLINKS_RST;
      holdoff_samples <= HOLDOFF_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_TURN_BLINKS:   turn_blinks     <= pwdata[CNT_W-1:0];
        REG_THANKS_BLINKS: thanks_blinks   <= pwdata[CNT_W-1:0];
        REG_HOLDOFF:       holdoff_samples <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_TURN_BLINKS:   prdata = {{(APB_DW-CNT_W){1'b0}}, turn_blinks};
      REG_THANKS_BLINKS: prdata = {{(APB_DW-CNT_W){1'b0}}, thanks_blinks};
      REG_HOLDOFF:       prdata = {{(APB_DW-CNT_W){1'b0}}, holdoff_samples};
      default:           prdata = '0;
    endcase
  end

  // Input accepted while the result register is free or draining
  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign smp         = {in_ch.relay_on, in_ch.left_lever_idle, in_ch.right_lever_idle};

  // Opposite lever touched during a turn blink
  assign cancel = ((mode == MODE_TURN_L) && !smp[BIT_RIGHT]) ||
                  ((mode == MODE_TURN_R) && !smp[BIT_LEFT]);

  // Next state for one sample
  always_comb begin
    mode_t m;
    cnt_t  limit;
    mode_next              = mode;
    blinks_done_next       = blinks_done;
    awaiting_relay_on_next = awaiting_relay_on;
    holdoff_left_next      = holdoff_left;
    hold_outputs_next      = hold_outputs;
    taken                  = 1'b0;
    m                      = mode;
    limit                  = (mode == MODE_THANKS) ? thanks_blinks : turn_blinks;

    if (smp == last_sample) begin
      if (holdoff_left != '0) begin
        holdoff_left_next = holdoff_left - 1'b1;
      end else begin
        taken = 1'b1;
        if (awaiting_relay_on) begin
          if (cancel) begin
            hold_outputs_next      = HOLD_NONE;
            mode_next              = MODE_IDLE;
            blinks_done_next       = '0;
            awaiting_relay_on_next = 1'b0;
            holdoff_left_next      = holdoff_samples;
          end else if (smp[BIT_RELAY]) begin
            awaiting_relay_on_next = 1'b0;
          end
        end else begin
          if (cancel) begin
            hold_outputs_next = HOLD_NONE;
            mode_next         = MODE_IDLE;
            blinks_done_next  = '0;
            holdoff_left_next = holdoff_samples;
            m                 = MODE_IDLE;
          end
          if (m == MODE_AWAIT) begin
            if (smp == SMP_RELEASED_OFF) begin
              hold_outputs_next = HOLD_NONE;
              mode_next         = MODE_IDLE;
              blinks_done_next  = '0;
              holdoff_left_next = holdoff_samples;
            end
          end else if (m != MODE_IDLE) begin
            // One blink per relay-off sample until the limit
            if (!smp[BIT_RELAY]) begin
              if (blinks_done >= limit) begin
                hold_outputs_next = HOLD_NONE;
                mode_next         = MODE_AWAIT;
              end else begin
                blinks_done_next       = blinks_done + 1'b1;
                awaiting_relay_on_next = 1'b1;
              end
            end
          end else begin
            // Idle judgment of the lever pattern
            case (smp)
              SMP_BOTH_ACTIVE_OFF: begin
                hold_outputs_next = HOLD_NONE;
                mode_next         = MODE_AWAIT;
              end
              SMP_HAZARD_ON: begin
                if (thanks_blinks != '0) begin
                  hold_outputs_next = HOLD_L | HOLD_R;
                  mode_next         = MODE_THANKS;
                  blinks_done_next  = 8'd1;
                end
              end
              SMP_LEFT_TAP_ON: begin
                if (turn_blinks != '0) begin
                  hold_outputs_next = hold_outputs_next | HOLD_L;
                  mode_next         = MODE_TURN_L;
                  blinks_done_next  = 8'd1;
                end
              end
              SMP_RIGHT_TAP_ON: begin
                if (turn_blinks != '0) begin
                  hold_outputs_next = hold_outputs_next | HOLD_R;
                  mode_next         = MODE_TURN_R;
                  blinks_done_next  = 8'd1;
                end
              end
              default: ;
            endcase
          end
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= MODE_IDLE;
      blinks_done       <= '0;
      last_sample       <= SMP_RELEASED_OFF;
      awaiting_relay_on <= 1'b0;
      holdoff_left      <= '0;
      hold_outputs      <= HOLD_NONE;
    end else if (in_fire) begin
      mode              <= mode_next;
      blinks_done       <= blinks_done_next;
      last_sample       <= smp;
      awaiting_relay_on <= awaiting_relay_on_next;
      holdoff_left      <= holdoff_left_next;
      hold_outputs      <= hold_outputs_next;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (in_fire) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_ch.hold_left    <= hold_outputs_next[0];
      out_ch.hold_right   <= hold_outputs_next[1];
      out_ch.mode_code    <= mode_next;
      out_ch.sample_taken <= taken;
    end
  end

endmodule

>>> hdl/ctsc_check.sv
// Port-level checks for the comfort turn signal controller.
// Depends on ctsc_pkg; bound to the top level at the end of this file.
module ctsc_check (
  input logic            clk,
  input logic            rst,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic            hold_left,
  input logic            hold_right,
  input ctsc_pkg::mode_t mode_code,
  input logic            sample_taken
);
  import ctsc_pkg::*;

  // No result is shown in the cycle after reset
  a_rst_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hold_left) && $stable(hold_right)
      && $stable(mode_code) && $stable(sample_taken))
    else $error("stalled result changed");

  // An empty result register never blocks input
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with result register empty");

  // No hold drive while idle or waiting for release
  a_no_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && (mode_code == MODE_IDLE || mode_code == MODE_AWAIT)
      |-> !hold_left && !hold_right)
    else $error("hold active outside blink modes");

  // A left turn drives the left side only
  a_turn_side: assert property (@(posedge clk) disable iff (rst)
    out_valid && (mode_code == MODE_TURN_L) |-> hold_left && !hold_right)
    else $error("left turn hold pattern wrong");

endmodule

bind comfort_turn_signal_controller ctsc_check u_ctsc_check (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .hold_left    (out_ch.hold_left),
  .hold_right   (out_ch.hold_right),
  .mode_code    (out_ch.mode_code),
  .sample_taken (out_ch.sample_taken)
);

>>> tb/comfort_turn_signal_controller_tb.sv
// Testbench for the comfort turn signal controller: lever/relay samples in, hold drives out.
// Scoreboard against an in-bench behavioral predictor, with APB register writes between phases.
// Depends on ctsc_pkg, ctsc_in_if/ctsc_out_if and the comfort_turn_signal_controller RTL.
module comfort_turn_signal_controller_tb;
  import ctsc_pkg::*;

  typedef struct packed {
    logic  hold_left;
    logic  hold_right;
    mode_t mode_code;
    logic  sample_taken;
  } ctl_result_t;

  localparam sample_t           RELAY_MASK  = sample_t'(1 << BIT_RELAY);
  localparam logic [APB_AW-1:0] UNUSED_ADDR = 4'hC;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  ctsc_in_if  in_ch ();
  ctsc_out_if out_ch ();

  comfort_turn_signal_controller u_top (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus and scoreboard storage
  sample_t     sample_q[$];
  ctl_result_t expected_q[$];
  int          errors;
  int          accepted;
  int          idle_pct;
  int          stall_pct;
  logic        rx_hold;

  // Predictor copy of the registers and state
  cnt_t    turn_blinks;
  cnt_t    thanks_blinks;
  cnt_t    holdoff_len;
  mode_t   ctl_mode;
  cnt_t    blinks_done;
  sample_t prev_sample;
  logic    wait_relay_on;
  cnt_t    holdoff_left;
  hold_t   hold_drive;

  task automatic log_mismatch(string msg);
    if (errors < 30) $display("%0t: mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic void reset_controller();
    turn_blinks   = TURN_BLINKS_RST;
    thanks_blinks = THANKS_BLINKS_RST;
    holdoff_len   = HOLDOFF_RST;
    ctl_mode      = MODE_IDLE;
    blinks_done   = '0;
    prev_sample   = SMP_RELEASED_OFF;
    wait_relay_on = 1'b0;
    holdoff_left  = '0;
    hold_drive    = HOLD_NONE;
  endfunction

  // Every return to idle drops the holds and restarts the holdoff
  function automatic void enter_idle();
    hold_drive    = HOLD_NONE;
    ctl_mode      = MODE_IDLE;
    blinks_done   = '0;
    wait_relay_on = 1'b0;
    holdoff_left  = holdoff_len;
  endfunction

  // Opposite lever active cancels a turn
  function automatic logic cancel_hit(sample_t s);
    return (ctl_mode == MODE_TURN_L && !s[BIT_RIGHT]) ||
           (ctl_mode == MODE_TURN_R && !s[BIT_LEFT]);
  endfunction

  function automatic void judge_from_idle(sample_t s);
    case (s)
      SMP_BOTH_ACTIVE_OFF: begin
        hold_drive = HOLD_NONE;
        ctl_mode   = MODE_AWAIT;
      end
      SMP_HAZARD_ON: begin
        if (thanks_blinks != '0) begin
          hold_drive  = HOLD_L | HOLD_R;
          ctl_mode    = MODE_THANKS;
          blinks_done = 8'd1;
        end
      end
      SMP_LEFT_TAP_ON: begin
        if (turn_blinks != '0) begin
          hold_drive  = hold_drive | HOLD_L;
          ctl_mode    = MODE_TURN_L;
          blinks_done = 8'd1;
        end
      end
      SMP_RIGHT_TAP_ON: begin
        if (turn_blinks != '0) begin
          hold_drive  = hold_drive | HOLD_R;
          ctl_mode    = MODE_TURN_R;
          blinks_done = 8'd1;
        end
      end
      default: ;
    endcase
  endfunction

  // One sample through the controller; returns the result it should produce
  function automatic ctl_result_t advance_controller(sample_t s);
    ctl_result_t r;
    logic        taken;
    cnt_t        limit;
    taken = 1'b0;
    if (s == prev_sample) begin
      if (holdoff_left != '0) begin
        holdoff_left = holdoff_left - 1'b1;
      end else begin
        taken = 1'b1;
        if (wait_relay_on) begin
          if (cancel_hit(s)) enter_idle();
          else if (s[BIT_RELAY]) wait_relay_on = 1'b0;
        end else begin
          // a cancel falls through to the idle judgment on the same sample
          if (cancel_hit(s)) enter_idle();
          if (ctl_mode == MODE_AWAIT) begin
            if (s == SMP_RELEASED_OFF) enter_idle();
          end else if (ctl_mode != MODE_IDLE) begin
            if (!s[BIT_RELAY]) begin
              limit = (ctl_mode == MODE_THANKS) ? thanks_blinks : turn_blinks;
              if (blinks_done >= limit) begin
                hold_drive = HOLD_NONE;
                ctl_mode   = MODE_AWAIT;
              end else begin
                blinks_done   = blinks_done + 1'b1;
                wait_relay_on = 1'b1;
              end
            end
          end else begin
            judge_from_idle(s);
          end
        end
      end
    end
    prev_sample    = s;
    r.hold_left    = |(hold_drive & HOLD_L);
    r.hold_right   = |(hold_drive & HOLD_R);
    r.mode_code    = ctl_mode;
    r.sample_taken = taken;
    return r;
  endfunction

  // Sample driver
  always @(posedge clk) begin : drive_samples
    sample_t nxt;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (sample_q.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
        nxt = sample_q.pop_front();
        in_ch.valid            <= 1'b1;
        in_ch.right_lever_idle <= nxt[BIT_RIGHT];
        in_ch.left_lever_idle  <= nxt[BIT_LEFT];
        in_ch.relay_on         <= nxt[BIT_RELAY];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver, with random stalls and the long hold-off
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= !rx_hold && ($urandom_range(99, 0) >= stall_pct);
  end

  // Monitor: check results, then predict for the sample accepted at this edge
  always @(posedge clk) begin : watch_transfers
    ctl_result_t want;
    sample_t     s;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          log_mismatch("result transfer with no sample outstanding");
        end else begin
          want = expected_q.pop_front();
          if (out_ch.hold_left !== want.hold_left)
            log_mismatch($sformatf("hold_left %b, want %b", out_ch.hold_left, want.hold_left));
          if (out_ch.hold_right !== want.hold_right)
            log_mismatch($sformatf("hold_right %b, want %b", out_ch.hold_right, want.hold_right));
          if (out_ch.mode_code !== want.mode_code)
            log_mismatch($sformatf("mode_code %0d, want %0d", out_ch.mode_code, want.mode_code));
          if (out_ch.sample_taken !== want.sample_taken)
            log_mismatch($sformatf("sample_taken %b, want %b",
                                   out_ch.sample_taken, want.sample_taken));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        s = '0;
        s[BIT_RIGHT] = in_ch.right_lever_idle;
        s[BIT_LEFT]  = in_ch.left_lever_idle;
        s[BIT_RELAY] = in_ch.relay_on;
        expected_q.push_back(advance_controller(s));
        accepted++;
      end
    end
  end

  // Long receiver hold-off early in the run, so the block backs up its input
  initial begin
    rx_hold = 1'b0;
    while (accepted < 150) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (80) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Run limit
  initial begin
    #4000000;
    $display("comfort_turn_signal_controller_tb: done, errors");
    $finish;
  end

  // APB write with optional read-back; upper data bits are junk that the block drops
  task automatic write_reg(logic [APB_AW-1:0] addr, cnt_t val, logic check);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {24'($urandom()), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (check) begin
      case (reg_idx_t'(addr[APB_AW-1:2]))
        REG_TURN_BLINKS:   turn_blinks   = val;
        REG_THANKS_BLINKS: thanks_blinks = val;
        REG_HOLDOFF:       holdoff_len   = val;
        default: ;
      endcase
      @(posedge clk);
      psel    <= 1'b1;
      pwrite  <= 1'b0;
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (prdata !== APB_DW'(val))
        log_mismatch($sformatf("register at %0d reads %0h, want %0h", addr, prdata, val));
    end
  endtask

  // Wait until no sample or result is in flight
  task automatic drain();
    do @(posedge clk);
    while (sample_q.size() != 0 || in_ch.valid || expected_q.size() != 0);
  endtask

  task automatic push_run(sample_t s, int n);
    repeat (n) sample_q.push_back(s);
  endtask

  // Mostly stable runs, now and then a single glitch sample
  function automatic int run_len();
    return ($urandom_range(9, 0) == 0) ? 1 : $urandom_range(3, 2);
  endfunction

  // One lever gesture with a train of relay cycles, or a burst of noise
  task automatic add_episode();
    int      kind;
    int      blinks;
    int      lim;
    sample_t start;
    sample_t levers;
    kind = $urandom_range(99, 0);
    if (kind < 20) begin
      repeat ($urandom_range(6, 1)) push_run(sample_t'($urandom_range(7, 0)), $urandom_range(2, 1));
    end else begin
      push_run(SMP_RELEASED_OFF, $urandom_range(6, 1));
      case ($urandom_range(9, 0))
        0, 1, 2: start = SMP_LEFT_TAP_ON;
        3, 4, 5: start = SMP_RIGHT_TAP_ON;
        6, 7:    start = SMP_HAZARD_ON;
        8:       start = SMP_BOTH_ACTIVE_OFF;
        default: start = sample_t'($urandom_range(7, 0));
      endcase
      push_run(start, run_len());
      lim = (turn_blinks > thanks_blinks) ? turn_blinks : thanks_blinks;
      if (lim > 6) lim = 6;
      blinks = $urandom_range(lim + 2, 0);
      repeat (blinks) begin
        case ($urandom_range(9, 0))
          0, 1, 2, 3: levers = SMP_RELEASED_OFF;
          9:          levers = sample_t'($urandom_range(7, 0));
          default:    levers = start;
        endcase
        push_run(levers & ~RELAY_MASK, run_len());
        push_run(levers | RELAY_MASK, run_len());
      end
      push_run(SMP_RELEASED_OFF, $urandom_range(4, 1));
    end
  endtask

  task automatic run_phase(cnt_t turn, cnt_t thanks, cnt_t hold, int idle, int stall, int n);
    drain();
    write_reg({REG_TURN_BLINKS, 2'b00}, turn, 1'b1);
    write_reg({REG_THANKS_BLINKS, 2'b00}, thanks, 1'b1);
    write_reg({REG_HOLDOFF, 2'b00}, hold, 1'b1);
    idle_pct  = idle;
    stall_pct = stall;
    while (sample_q.size() < n) add_episode();
  endtask

  // Main sequence
  initial begin
    in_ch.valid            = 1'b0;
    in_ch.right_lever_idle = 1'b1;
    in_ch.left_lever_idle  = 1'b1;
    in_ch.relay_on         = 1'b0;
    out_ch.ready           = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    errors                 = 0;
    accepted               = 0;
    idle_pct               = 0;
    stall_pct              = 0;
    reset_controller();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults: hazard ignored with thanks off, left turn, blink,
    // then the right lever cancels and latches the right side at once
    push_run(SMP_RELEASED_OFF, 2);
    push_run(SMP_HAZARD_ON, 2);
    push_run(SMP_LEFT_TAP_ON, 2);
    push_run(3'b001, 2);
    push_run(SMP_HAZARD_ON, 2);
    push_run(SMP_RIGHT_TAP_ON, 2);
    drain();

    // Holdoff from the cancel swallows these samples; both levers then cancel the turn to await
    write_reg(UNUSED_ADDR, 8'hA5, 1'b0);
    write_reg({REG_TURN_BLINKS, 2'b00}, 8'd1, 1'b1);
    write_reg({REG_THANKS_BLINKS, 2'b00}, 8'd2, 1'b1);
    write_reg({REG_HOLDOFF, 2'b00}, 8'd1, 1'b1);
    push_run(3'b010, 2);
    push_run(SMP_RELEASED_OFF, 3);
    push_run(SMP_HAZARD_ON, 2);
    push_run(SMP_BOTH_ACTIVE_OFF, 2);
    push_run(3'b100, 2);
    push_run(SMP_RELEASED_OFF, 3);
    push_run(SMP_BOTH_ACTIVE_OFF, 2);

    // Random phases across register settings and idling patterns
    run_phase(8'd3,   8'd2,   8'd2,   0,  0,  210);
    run_phase(8'd0,   8'd5,   8'd0,   82, 0,  210);
    run_phase(8'd255, 8'd0,   8'd1,   0,  82, 210);
    run_phase(8'd1,   8'd1,   8'd255, 38, 38, 150);
    run_phase(8'd2,   8'd255, 8'd3,   0,  0,  210);
    run_phase(8'd5,   8'd3,   8'd0,   82, 0,  210);
    run_phase(8'd1,   8'd1,   8'd0,   0,  82, 210);
    run_phase(8'd4,   8'd4,   8'd2,   38, 38, 210);

    drain();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("comfort_turn_signal_controller_tb: done, clean");
    end else begin
      $display("comfort_turn_signal_controller_tb: done, errors");
    end
    $finish;
  end

endmodule
